>>> src/ioc_pkg.sv
package ioc_pkg;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] reg_index;
    logic [7:0] write_data;
    logic [1:0] event_bank;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       fiq_line;
  } out_word_t;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_SET   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [4:0] IDX_KBD    = 5'd1;
  localparam logic [4:0] IDX_STAT_A = 5'd4;
  localparam logic [4:0] IDX_REQ_A  = 5'd5;
  localparam logic [4:0] IDX_MASK_A = 5'd6;
  localparam logic [4:0] IDX_STAT_B = 5'd8;
  localparam logic [4:0] IDX_REQ_B  = 5'd9;
  localparam logic [4:0] IDX_MASK_B = 5'd10;
  localparam logic [4:0] IDX_STAT_F = 5'd12;
  localparam logic [4:0] IDX_REQ_F  = 5'd13;
  localparam logic [4:0] IDX_MASK_F = 5'd14;

  localparam logic [1:0] TMR_LATCH_LO = 2'd0;
  localparam logic [1:0] TMR_LATCH_HI = 2'd1;
  localparam logic [1:0] TMR_LOAD     = 2'd2;
  localparam logic [1:0] TMR_COPY     = 2'd3;

  localparam logic [1:0] BANK_A = 2'd0;
  localparam logic [1:0] BANK_B = 2'd1;
  localparam logic [1:0] BANK_F = 2'd2;

  localparam logic [1:0] CFG_T0_BIT = 2'd0;
  localparam logic [1:0] CFG_T1_BIT = 2'd1;
  localparam logic [1:0] CFG_TX_BIT = 2'd2;
  localparam logic [1:0] CFG_RX_BIT = 2'd3;

  localparam logic [7:0]  FORCED_BIT  = 8'h80;
  localparam logic [16:0] FULL_PERIOD = 17'h10001;
  localparam logic [7:0]  STAT_A_RST  = 8'h10;
  localparam logic [7:0]  STAT_B_RST  = 8'h02;

endpackage

>>> src/ioc_state.sv
module ioc_state
  import ioc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_word_t  item_i,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [2:0] cfg_data_i,
  output out_word_t result_o
);

  logic [2:0] t0_bit_q, t1_bit_q, tx_bit_q, rx_bit_q;
  logic [7:0] stat_a_q, stat_b_q, stat_f_q, mask_a_q, mask_b_q, mask_f_q;
  logic [7:0] stat_a_d, stat_b_d, stat_f_d, mask_a_d, mask_b_d, mask_f_d;
  logic [15:0] latch_q [4];
  logic [15:0] latch_d [4];
  logic [16:0] count_q [4];
  logic [16:0] count_d [4];
  logic [15:0] rb_q [4];
  logic [15:0] rb_d [4];
  logic [7:0]  rd;
  logic [1:0]  tsel;
  logic [1:0]  tsub;

  function automatic logic [16:0] period_of(input logic [15:0] latch);
    period_of = (latch == 16'd0) ? FULL_PERIOD : ({1'b0, latch} + 17'd1);
  endfunction

  assign tsel = item_i.reg_index[3:2];
  assign tsub = item_i.reg_index[1:0];

  always_comb begin
    stat_a_d = stat_a_q;
    stat_b_d = stat_b_q;
    stat_f_d = stat_f_q;
    mask_a_d = mask_a_q;
    mask_b_d = mask_b_q;
    mask_f_d = mask_f_q;
    latch_d  = latch_q;
    count_d  = count_q;
    rb_d     = rb_q;
    rd       = 8'd0;
    if (fire_i) begin
      unique case (item_i.op)
        OP_READ: begin
          if (item_i.reg_index[4]) begin
            if (tsub == TMR_LATCH_LO) begin
              rd = rb_q[tsel][7:0];
            end else if (tsub == TMR_LATCH_HI) begin
              rd = rb_q[tsel][15:8];
            end
          end else begin
            unique case (item_i.reg_index)
              IDX_KBD:    stat_b_d = stat_b_q & ~(8'd1 << rx_bit_q);
              IDX_STAT_A: rd = stat_a_q | FORCED_BIT;
              IDX_REQ_A:  rd = (stat_a_q | FORCED_BIT) & mask_a_q;
              IDX_MASK_A: rd = mask_a_q;
              IDX_STAT_B: rd = stat_b_q;
              IDX_REQ_B:  rd = stat_b_q & mask_b_q;
              IDX_MASK_B: rd = mask_b_q;
              IDX_STAT_F: rd = stat_f_q | FORCED_BIT;
              IDX_REQ_F:  rd = (stat_f_q | FORCED_BIT) & mask_f_q;
              IDX_MASK_F: rd = mask_f_q;
              default:    rd = 8'd0;
            endcase
          end
        end
        OP_WRITE: begin
          if (item_i.reg_index[4]) begin
            unique case (tsub)
              TMR_LATCH_LO: latch_d[tsel][7:0] = item_i.write_data;
              TMR_LATCH_HI: latch_d[tsel][15:8] = item_i.write_data;
              TMR_LOAD: begin
                count_d[tsel] = tsel[1] ? {1'b0, latch_q[tsel]} : period_of(latch_q[tsel]);
              end
              TMR_COPY: rb_d[tsel] = count_q[tsel][15:0];
            endcase
          end else begin
            unique case (item_i.reg_index)
              IDX_KBD:    stat_b_d = stat_b_q & ~(8'd1 << tx_bit_q);
              IDX_REQ_A:  stat_a_d = stat_a_q & ~item_i.write_data;
              IDX_MASK_A: mask_a_d = item_i.write_data;
              IDX_MASK_B: mask_b_d = item_i.write_data;
              IDX_MASK_F: mask_f_d = item_i.write_data;
              default:    ;
            endcase
          end
        end
        OP_TICK: begin
          if (count_q[0] <= 17'd1) begin
            stat_a_d   = stat_a_d | (8'd1 << t0_bit_q);
            count_d[0] = period_of(latch_q[0]);
          end else begin
            count_d[0] = count_q[0] - 17'd1;
          end
          if (count_q[1] <= 17'd1) begin
            stat_a_d   = stat_a_d | (8'd1 << t1_bit_q);
            count_d[1] = period_of(latch_q[1]);
          end else begin
            count_d[1] = count_q[1] - 17'd1;
          end
        end
        OP_SET: begin
          unique case (item_i.event_bank)
            BANK_A:  stat_a_d = stat_a_q | item_i.write_data;
            BANK_B:  stat_b_d = stat_b_q | item_i.write_data;
            BANK_F:  stat_f_d = stat_f_q | item_i.write_data;
            default: ;
          endcase
        end
        OP_CLEAR: begin
          unique case (item_i.event_bank)
            BANK_A:  stat_a_d = stat_a_q & ~item_i.write_data;
            BANK_B:  stat_b_d = stat_b_q & ~item_i.write_data;
            BANK_F:  stat_f_d = stat_f_q & ~item_i.write_data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign result_o.read_data = rd;
  assign result_o.irq_line  = |((mask_a_d & (stat_a_d | FORCED_BIT)) | (mask_b_d & stat_b_d));
  assign result_o.fiq_line  = |(mask_f_d & (stat_f_d | FORCED_BIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_bit_q <= 3'd5;
      t1_bit_q <= 3'd6;
      tx_bit_q <= 3'd6;
      rx_bit_q <= 3'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_T0_BIT: t0_bit_q <= cfg_data_i;
        CFG_T1_BIT: t1_bit_q <= cfg_data_i;
        CFG_TX_BIT: tx_bit_q <= cfg_data_i;
        CFG_RX_BIT: rx_bit_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_a_q <= STAT_A_RST;
      stat_b_q <= STAT_B_RST;
      stat_f_q <= 8'd0;
      mask_a_q <= 8'd0;
      mask_b_q <= 8'd0;
      mask_f_q <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        latch_q[i] <= 16'd0;
        count_q[i] <= 17'd0;
        rb_q[i]    <= 16'd0;
      end
    end else begin
      stat_a_q <= stat_a_d;
      stat_b_q <= stat_b_d;
      stat_f_q <= stat_f_d;
      mask_a_q <= mask_a_d;
      mask_b_q <= mask_b_d;
      mask_f_q <= mask_f_d;
      latch_q  <= latch_d;
      count_q  <= count_d;
      rb_q     <= rb_d;
    end
  end

endmodule

>>> src/io_interrupt_timer_controller_core.sv
// Interrupt and timer controller with three 8-bit interrupt banks and four
// 16-bit timers. Each input word is a bus read, a bus write, a timer tick,
// or a set or clear event on one bank. Each word produces exactly one output
// word: the read byte plus the IRQ and FIQ lines after that word took effect.
// Both channels use valid and ready. An accepted word lands in an input
// register and is applied to the state once the output register is empty or
// is being taken; its result is written to the output register at the same
// edge that updates the state. Throughput is one word per cycle while the
// receiver does not stall.
// When the receiver stalls, the result holds in the output register and one
// further word may wait in the input register; ready drops only when both
// are full and the output is not being taken.
// The configuration port writes one of the four bit-position registers per
// cycle and must be used only while the block is idle; the block itself does
// not enforce this. Reset clears both valid flags and puts the banks, masks,
// timers and configuration back to their power-on values.
module io_interrupt_timer_controller_core
  import ioc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_word_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [2:0] cfg_data_i
);

  logic      inq_valid_q;
  in_word_t  inq_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t result;
  logic      fire;

  assign fire       = inq_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !inq_valid_q || fire;

  ioc_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (inq_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        inq_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_fire_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("applied word did not produce a result");

  a_accept_fills_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> inq_valid_q)
    else $error("accepted word was not held in the input register");

  a_no_fire_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !fire)
    else $error("result overwritten while the receiver stalls");

  a_waiting_word_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inq_valid_q && !fire |=> inq_valid_q && $stable(inq_q))
    else $error("waiting input word was lost or changed");

endmodule
